[design/eclb_pkg.sv]
// Package for the error code LED blinker: payload structs, phase codes,
// timing constants and the control struct passed to the sequencer. No dependencies.
`default_nettype none

package eclb_pkg;

   localparam int unsigned CodeW  = 14;
   localparam int unsigned TimerW = 10;
   localparam int unsigned CountW = 5;

   localparam logic [CodeW-1:0]  CodeMax    = 14'd9999;
   localparam logic [TimerW-1:0] ToggleMs   = 10'd250;
   localparam logic [TimerW-1:0] PulseOnMs  = 10'd10;
   localparam logic [TimerW-1:0] PulseOffMs = 10'd240;
   localparam logic [TimerW-1:0] GapMs      = 10'd1000;
   localparam logic [3:0]        UnitsZero  = 4'd10;

   // Input item actions
   localparam logic ActTick  = 1'b0;
   localparam logic ActStart = 1'b1;

   typedef enum logic [2:0] {
      PH_THOUS = 3'd0,
      PH_HUND  = 3'd1,
      PH_TENS  = 3'd2,
      PH_UNITS = 3'd3,
      PH_GAP   = 3'd4
   } eclb_phase_type;

   typedef struct packed {
      logic             action;
      logic [CodeW-1:0] code;
   } eclb_req_type;

   typedef struct packed {
      logic led;
      logic running;
   } eclb_rsp_type;

   // [0] thousands, [1] hundreds, [2] tens, [3] units
   typedef logic [3:0][3:0] eclb_digits_type;

   typedef struct packed {
      logic            adv;
      logic            start;
      logic            idle_level;
      eclb_digits_type digits;
   } eclb_cmd_type;

endpackage

`default_nettype wire

[design/eclb_digit_split.sv]
// Splits a code, saturated to 9999, into four decimal digits; a zero units digit is given as ten.
// Uses eclb_pkg; constant reciprocal multiplies, no dividers.
`default_nettype none

module eclb_digit_split (
   input  wire logic [eclb_pkg::CodeW-1:0] code,
   output eclb_pkg::eclb_digits_type       digits
);
   import eclb_pkg::*;

   localparam logic [12:0] Recip10   = 13'd6554;   // 2^16 / 10, rounded up
   localparam logic [13:0] Recip100  = 14'd10486;  // 2^20 / 100, rounded up
   localparam logic [14:0] Recip1000 = 15'd16778;  // 2^24 / 1000, rounded up

   logic [CodeW-1:0] sat;
   logic [27:0]      p10;
   logic [27:0]      p100;
   logic [27:0]      p1000;
   logic [9:0]       q10;
   logic [6:0]       q100;
   logic [3:0]       q1000;
   logic [13:0]      q10x10;
   logic [9:0]       q100x10;
   logic [6:0]       q1000x10;
   logic [13:0]      units_w;
   logic [9:0]       tens_w;
   logic [6:0]       hund_w;

   always_comb begin
      sat      = (code > CodeMax) ? CodeMax : code;
      p10      = 28'(sat) * 28'(Recip10);
      p100     = 28'(sat) * 28'(Recip100);
      p1000    = 28'(sat) * 28'(Recip1000);
      q10      = p10[25:16];
      q100     = p100[26:20];
      q1000    = p1000[27:24];
      q10x10   = 14'({q10, 3'b000}) + 14'({q10, 1'b0});
      q100x10  = 10'({q100, 3'b000}) + 10'({q100, 1'b0});
      q1000x10 = 7'({q1000, 3'b000}) + 7'({q1000, 1'b0});
      units_w  = sat - q10x10;
      tens_w   = q10 - q100x10;
      hund_w   = q100 - q1000x10;

      digits[0] = q1000;
      digits[1] = hund_w[3:0];
      digits[2] = tens_w[3:0];
      digits[3] = (units_w[3:0] == 4'd0) ? UnitsZero : units_w[3:0];
   end

endmodule

`default_nettype wire

[design/eclb_sequencer.sv]
// Blink sequencer: digit store, phase, counts, ms timer and LED level.
// Uses eclb_pkg; one item applied per advance, state doubles as the result.
`default_nettype none

module eclb_sequencer (
   input  wire logic           clock,
   input  wire logic           reset,
   input  eclb_pkg::eclb_cmd_type cmd,
   output logic               led,
   output logic               running
);
   import eclb_pkg::*;

   eclb_digits_type   digit_store_ff, digit_store_in;
   eclb_phase_type    phase_ff, phase_in;
   logic [CountW-1:0] blink_count_ff, blink_count_in;
   logic              pulse_half_ff, pulse_half_in;
   logic [TimerW-1:0] ms_timer_ff, ms_timer_in;
   logic              led_level_ff, led_level_in;
   logic              active_ff, active_in;

   logic [3:0]        cur_n;
   logic              cur_acts;
   logic [2:0]        scan_from;
   logic [3:0]        nz;
   logic              pick_found;
   logic [1:0]        pick;
   eclb_phase_type    eff_ph;
   logic [CountW-1:0] eff_bc;
   logic              eff_half;
   logic [TimerW-1:0] timer_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_store_ff <= '0;
         phase_ff       <= PH_THOUS;
         blink_count_ff <= '0;
         pulse_half_ff  <= 1'b0;
         ms_timer_ff    <= '0;
         led_level_ff   <= 1'b0;
         active_ff      <= 1'b0;
      end else begin
         digit_store_ff <= digit_store_in;
         phase_ff       <= phase_in;
         blink_count_ff <= blink_count_in;
         pulse_half_ff  <= pulse_half_in;
         ms_timer_ff    <= ms_timer_in;
         led_level_ff   <= led_level_in;
         active_ff      <= active_in;
      end
   end

   always_comb begin
      cur_n = digit_store_ff[phase_ff[1:0]];

      // does the current phase still have work at this action
      unique case (phase_ff)
         PH_THOUS, PH_TENS: cur_acts = blink_count_ff < {cur_n, 1'b0};
         PH_HUND, PH_UNITS: cur_acts = pulse_half_ff || (blink_count_ff < {1'b0, cur_n});
         default:           cur_acts = !pulse_half_ff;
      endcase

      // otherwise skip ahead to the first digit phase with a nonzero digit
      if (phase_ff == PH_THOUS || phase_ff == PH_HUND ||
          phase_ff == PH_TENS  || phase_ff == PH_UNITS) begin
         scan_from = 3'(phase_ff) + 3'd1;
      end else begin
         scan_from = 3'd0;
      end
      for (int q = 0; q < 4; q++) begin
         nz[q] = (digit_store_ff[q] != 4'd0) && (3'(q) >= scan_from);
      end
      pick_found = 1'b1;
      if (nz[0]) begin
         pick = 2'd0;
      end else if (nz[1]) begin
         pick = 2'd1;
      end else if (nz[2]) begin
         pick = 2'd2;
      end else if (nz[3]) begin
         pick = 2'd3;
      end else begin
         pick       = 2'd0;
         pick_found = 1'b0;
      end

      if (cur_acts) begin
         eff_ph   = phase_ff;
         eff_bc   = blink_count_ff;
         eff_half = pulse_half_ff;
      end else begin
         eff_ph   = pick_found ? eclb_phase_type'({1'b0, pick}) : PH_GAP;
         eff_bc   = '0;
         eff_half = 1'b0;
      end

      timer_dec = (ms_timer_ff != '0) ? ms_timer_ff - 10'd1 : ms_timer_ff;

      digit_store_in = digit_store_ff;
      phase_in       = phase_ff;
      blink_count_in = blink_count_ff;
      pulse_half_in  = pulse_half_ff;
      ms_timer_in    = ms_timer_ff;
      led_level_in   = led_level_ff;
      active_in      = active_ff;

      if (cmd.adv && cmd.start) begin
         digit_store_in = cmd.digits;
         phase_in       = PH_THOUS;
         blink_count_in = '0;
         pulse_half_in  = 1'b0;
         ms_timer_in    = '0;
         led_level_in   = cmd.idle_level;
         active_in      = 1'b1;
      end else if (cmd.adv && active_ff) begin
         ms_timer_in = timer_dec;
         if (timer_dec == '0) begin
            phase_in = eff_ph;
            unique case (eff_ph)
               PH_THOUS, PH_TENS: begin
                  led_level_in   = !led_level_ff;
                  blink_count_in = eff_bc + 5'd1;
                  pulse_half_in  = 1'b0;
                  ms_timer_in    = ToggleMs;
               end
               PH_HUND, PH_UNITS: begin
                  led_level_in = !led_level_ff;
                  if (eff_half) begin
                     pulse_half_in  = 1'b0;
                     blink_count_in = eff_bc + 5'd1;
                     ms_timer_in    = PulseOffMs;
                  end else begin
                     pulse_half_in  = 1'b1;
                     blink_count_in = eff_bc;
                     ms_timer_in    = PulseOnMs;
                  end
               end
               default: begin
                  pulse_half_in  = 1'b1;
                  blink_count_in = eff_bc;
                  ms_timer_in    = GapMs;
               end
            endcase
         end
      end
   end

   assign led     = led_level_ff;
   assign running = active_ff;

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.adv && cmd.start |=> ms_timer_ff == '0 && phase_ff == PH_THOUS && active_ff)
      else $error("start did not reset the sequence");

   a_running_sticks: assert property (@(posedge clock) disable iff (reset)
      active_ff |=> active_ff)
      else $error("running dropped");

   a_half_in_pulse: assert property (@(posedge clock) disable iff (reset)
      pulse_half_ff |-> phase_ff == PH_HUND || phase_ff == PH_UNITS || phase_ff == PH_GAP)
      else $error("pulse half set outside pulse or gap phase");

endmodule

`default_nettype wire

[design/error_code_led_blinker_unit.sv]
// Top level of the error code LED blinker: input register, digit split,
// sequencer and result valid. Uses eclb_pkg, eclb_digit_split, eclb_sequencer.
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  req_data (action, code)
//   rsp       out        rsp_valid/rsp_stall  rsp_data (led, running)
//   csr       in         csr_wr_en            csr_wr_data (idle_level)
//
// One item per clock sustained while rsp_stall is low; a result passes through
// the input register, then the sequencer state that is also the result register,
// before it can transfer out.
// The path between them runs through the constant multiplies of the digit split on start,
// or the timer decrement and action select on a tick.
// Synchronous active-high reset clears all control state and idle_level.
// A stalled result holds; req_stall rises only when both stages are full.
`default_nettype none

module error_code_led_blinker_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  eclb_pkg::eclb_req_type     req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output eclb_pkg::eclb_rsp_type     rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data
);
   import eclb_pkg::*;

   logic            req_valid_ff, req_valid_in;
   eclb_req_type    req_data_ff, req_data_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            idle_level_ff, idle_level_in;
   logic            out_free;
   logic            item_adv;
   eclb_digits_type digits;
   eclb_cmd_type    cmd;
   logic            seq_led;
   logic            seq_running;

   // the result stage can take an item when empty or draining this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign item_adv  = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         idle_level_ff <= 1'b0;
      end else begin
         req_valid_ff  <= req_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         idle_level_ff <= idle_level_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
   end

   always_comb begin
      req_valid_in  = req_valid_ff;
      req_data_in   = req_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      idle_level_in = idle_level_ff;

      // input register loads on every transfer, empties when it moves on
      if (!req_stall) begin
         req_valid_in = req_valid;
         if (req_valid) begin
            req_data_in = req_data;
         end
      end
      if (out_free) begin
         rsp_valid_in = req_valid_ff;
      end
      if (csr_wr_en) begin
         idle_level_in = csr_wr_data;
      end
   end

   eclb_digit_split u_digit_split (
      .code   (req_data_ff.code),
      .digits (digits)
   );

   always_comb begin
      cmd.adv        = item_adv;
      cmd.start      = (req_data_ff.action == ActStart);
      cmd.idle_level = idle_level_ff;
      cmd.digits     = digits;
   end

   eclb_sequencer u_sequencer (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .led     (seq_led),
      .running (seq_running)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data.led     = seq_led;
   assign rsp_data.running = seq_running;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> req_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      item_adv && req_data_ff.action == ActStart |=> rsp_valid && rsp_data.running)
      else $error("start transfer did not yield a running result");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !req_valid_ff |=> !rsp_valid_ff)
      else $error("result valid without a new item");

endmodule

`default_nettype wire

[dv/eclb_checker.sv]
`timescale 1ns / 100ps
// Checker for the error code LED blinker: watches the req, rsp and csr ports,
// predicts led/running per transfer and compares. Depends on eclb_pkg.
module eclb_checker
   import eclb_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   input  wire logic   req_stall,
   input  eclb_req_type req_data,
   input  wire logic   rsp_valid,
   input  wire logic   rsp_stall,
   input  eclb_rsp_type rsp_data,
   input  wire logic   csr_wr_en,
   input  wire logic   csr_wr_data,
   output int          mismatches,
   output int          outstanding,
   output int          checked,
   output int          wraps
);

   logic [3:0]        digit_q [4];   // thousands, hundreds, tens, units
   eclb_phase_type    phase_q;
   logic [CountW-1:0] blinks_q;
   logic              in_pulse_q;    // mid pulse, or mid gap
   logic [TimerW-1:0] ms_left_q;
   logic              led_q;
   logic              running_q;
   logic              idle_level_q;

   eclb_rsp_type      led_expect_q [$];

   function automatic void clear_blinker();
      for (int i = 0; i < 4; i++) digit_q[i] = '0;
      phase_q      = PH_THOUS;
      blinks_q     = '0;
      in_pulse_q   = 1'b0;
      ms_left_q    = '0;
      led_q        = 1'b0;
      running_q    = 1'b0;
      idle_level_q = 1'b0;
   endfunction

   function automatic void next_digit();
      phase_q    = eclb_phase_type'(phase_q + 3'd1);
      blinks_q   = '0;
      in_pulse_q = 1'b0;
   endfunction

   // Action due when the ms timer hits zero; empty digits fall straight through.
   function automatic void fire_action();
      int digit;
      for (int guard = 0; guard < 8; guard++) begin
         digit = int'(digit_q[phase_q[1:0]]);
         if (phase_q == PH_THOUS || phase_q == PH_TENS) begin
            if (int'(blinks_q) < 2 * digit) begin
               led_q     = ~led_q;
               blinks_q  = blinks_q + 1'b1;
               ms_left_q = ToggleMs;
               return;
            end
            next_digit();
         end else if (phase_q == PH_HUND || phase_q == PH_UNITS) begin
            if (in_pulse_q) begin
               led_q      = ~led_q;
               in_pulse_q = 1'b0;
               blinks_q   = blinks_q + 1'b1;
               ms_left_q  = PulseOffMs;
               return;
            end
            if (int'(blinks_q) < digit) begin
               led_q      = ~led_q;
               in_pulse_q = 1'b1;
               ms_left_q  = PulseOnMs;
               return;
            end
            next_digit();
         end else begin
            if (!in_pulse_q) begin
               in_pulse_q = 1'b1;
               ms_left_q  = GapMs;
               return;
            end
            phase_q    = PH_THOUS;
            blinks_q   = '0;
            in_pulse_q = 1'b0;
            wraps++;
         end
      end
   endfunction

   function automatic eclb_rsp_type predict_led(eclb_req_type item);
      eclb_rsp_type res;
      int           c;
      if (item.action == ActStart) begin
         c = (item.code > CodeMax) ? int'(CodeMax) : int'(item.code);
         digit_q[0] = 4'(c / 1000);
         digit_q[1] = 4'((c % 1000) / 100);
         digit_q[2] = 4'((c % 100) / 10);
         digit_q[3] = (c % 10 == 0) ? UnitsZero : 4'(c % 10);
         phase_q    = PH_THOUS;
         blinks_q   = '0;
         in_pulse_q = 1'b0;
         ms_left_q  = '0;
         led_q      = idle_level_q;
         running_q  = 1'b1;
      end else if (running_q) begin
         if (ms_left_q != '0) ms_left_q = ms_left_q - 1'b1;
         if (ms_left_q == '0) fire_action();
      end
      res.led     = led_q;
      res.running = running_q;
      return res;
   endfunction

   always @(posedge clock) begin
      eclb_rsp_type want;
      if (reset) begin
         clear_blinker();
         led_expect_q.delete();
      end else begin
         // result side first: a result never belongs to a same-edge request
         if (rsp_valid && !rsp_stall) begin
            if (led_expect_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual led %0b running %0b",
                        $time, rsp_data.led, rsp_data.running);
            end else begin
               want = led_expect_q.pop_front();
               checked++;
               if (rsp_data.led !== want.led) begin
                  mismatches++;
                  $display("%0t: led expected %0b actual %0b", $time, want.led, rsp_data.led);
               end
               if (rsp_data.running !== want.running) begin
                  mismatches++;
                  $display("%0t: running expected %0b actual %0b",
                           $time, want.running, rsp_data.running);
               end
            end
         end
         if (csr_wr_en) idle_level_q = csr_wr_data;
         if (req_valid && !req_stall) led_expect_q.push_back(predict_led(req_data));
      end
      outstanding = led_expect_q.size();
   end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Top of the error code LED blinker testbench: clock, reset, stimulus and
// verdict. Depends on eclb_pkg, error_code_led_blinker_unit and eclb_checker.
module tb_top;
   import eclb_pkg::*;

   localparam int CycleLimit = 20000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   eclb_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   eclb_rsp_type rsp_data;
   logic         csr_wr_en;
   logic         csr_wr_data;

   // set during the long show of a full code: neither side idles then
   logic         no_idle;

   int mismatches, outstanding, checked, wraps;
   int items_sent, starts_sent, ticks_sent, capped_codes;
   int cycle_count;

   error_code_led_blinker_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   eclb_checker blink_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked),
      .wraps       (wraps)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: stall about 27% of cycles, changed only at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < 27);
   end

   // Watchdog on total cycles.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // One transfer on req. Optional idle cycles first, then valid held with a
   // fixed payload until a rising edge sees no stall.
   task automatic send_item(input logic act, input logic [CodeW-1:0] code);
      while (!no_idle && $urandom_range(0, 99) < 27) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_data.action <= act;
      req_data.code   <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (act == ActStart) begin
         starts_sent++;
         if (code > CodeMax) capped_codes++;
      end else begin
         ticks_sent++;
      end
   endtask

   // Ticks carry a random code; the block must ignore it.
   task automatic tick_run(input int count);
      repeat (count) send_item(ActTick, CodeW'($urandom_range(0, 16383)));
   endtask

   task automatic show_code(input logic [CodeW-1:0] code, input int ticks);
      send_item(ActStart, code);
      tick_run(ticks);
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Register write only with the pipe empty.
   task automatic write_idle_level(input logic level);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= level;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Codes: full 14-bit range (saturation, every bit), in-range, or small
   // digits so that short tick runs still get through several digits.
   function automatic logic [CodeW-1:0] pick_code();
      case ($urandom_range(0, 3))
         0: return CodeW'($urandom_range(0, 16383));
         1: return CodeW'($urandom_range(0, 9999));
         default: return CodeW'($urandom_range(0, 2) * 1000 + $urandom_range(0, 2) * 100 +
                                $urandom_range(0, 2) * 10 + $urandom_range(0, 2));
      endcase
   endfunction

   initial begin
      int goal;
      int pick;
      bit flipped;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      no_idle     = 1'b0;
      flipped     = 1'b0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // ---- directed part, idle level high ----
      write_idle_level(1'b1);
      tick_run(2);                      // ticks before any start do nothing
      show_code(CodeW'(0), 3);          // units zero shown as ten pulses
      show_code(CodeW'(9999), 1);       // largest legal code
      show_code(CodeW'(10000), 1);      // just above the cap
      show_code(CodeW'(16383), 1);      // all ones, capped
      show_code(CodeW'(5461), 1);       // alternating bit patterns
      show_code(CodeW'(10922), 1);
      show_code(CodeW'(1234), 2);       // restart while running

      // ---- random part, idle level low then high ----
      write_idle_level(1'b0);
      goal = items_sent + 250;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // well-formed: a start, then a run of ticks
            show_code(pick_code(), $urandom_range(1, 40));
         end else if (pick < 95) begin
            // noise: random actions and codes back to back
            repeat ($urandom_range(1, 8))
               send_item($urandom_range(0, 99) < 30 ? ActStart : ActTick,
                         CodeW'($urandom_range(0, 16383)));
         end else begin
            wait_drained();             // sender holds off until all results are in
         end
         if (!flipped && items_sent > goal - 125) begin
            write_idle_level(1'b1);
            flipped = 1'b1;
         end
      end

      // ---- long run: a whole sequence, the gap and one repeat ----
      wait_drained();
      no_idle = 1'b1;                   // long stretch with no idling either side
      show_code(CodeW'(1), 1255);       // units only: one pulse, the gap, then a repeat
      wait_drained();
      no_idle = 1'b0;
      write_idle_level(1'b0);           // changed while running, no effect yet
      tick_run(5);
      show_code(CodeW'(1111), 5);       // new idle level picked up here
      wait_drained();

      // let the pipe settle past its latency
      repeat (8) @(posedge clock);
      $display("covered %0d transfers: %0d starts (%0d capped codes), %0d ticks",
               items_sent, starts_sent, capped_codes, ticks_sent);
      $display("checked %0d results, %0d full sequence repeats", checked, wraps);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[error_code_led_blinker_unit.f]
design/eclb_pkg.sv
design/eclb_digit_split.sv
design/eclb_sequencer.sv
design/error_code_led_blinker_unit.sv
dv/eclb_checker.sv
dv/tb_top.sv
